@@ rtl/tkx_pkg.sv @@
package tkx_pkg;

  localparam int TW_N         = 624;
  localparam int TW_M         = 397;
  localparam int WARMUP_DRAWS = 624;
  localparam int NUM_SEEDS    = 6;

  localparam int POS_W  = $clog2(TW_N);
  localparam int LEFT_W = $clog2(WARMUP_DRAWS + 1) > 5 ? $clog2(WARMUP_DRAWS + 1) : 5;
  localparam int SEL_W  = $clog2(NUM_SEEDS);
  localparam int SKIP_W = 5;
  localparam int IDX_W  = 3;

  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(TW_N - 1);
  localparam logic [POS_W-1:0]  POS_M     = POS_W'(TW_M);
  localparam logic [POS_W-1:0]  POS_NM    = POS_W'(TW_N - TW_M);
  localparam logic [SEL_W-1:0]  SEL_LAST  = SEL_W'(NUM_SEEDS - 1);
  localparam logic [LEFT_W-1:0] WARMUP_CNT = LEFT_W'(WARMUP_DRAWS);

  localparam logic [31:0] TW_MATRIX   = 32'h9908b0df;
  localparam logic [31:0] TW_TEMPER_B = 32'h9d2c5680;
  localparam logic [31:0] TW_TEMPER_C = 32'hefc60000;

  localparam logic [IDX_W-1:0]  REG_SKIP_COUNT = IDX_W'(6);
  localparam logic [SKIP_W-1:0] SKIP_RESET     = SKIP_W'(16);

  localparam logic ACT_RESEED = 1'b0;
  localparam logic ACT_CIPHER = 1'b1;

  typedef logic [NUM_SEEDS-1:0][31:0] tkx_seeds_t;

  typedef struct packed {
    logic        action;
    logic [31:0] data_word;
    logic        last_word;
  } tkx_cmd_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } tkx_res_t;

  function automatic logic [31:0] tkx_temper(input logic [31:0] y);
    logic [31:0] r;
    r = y ^ (y >> 11);
    r = r ^ ((r << 7) & TW_TEMPER_B);
    r = r ^ ((r << 15) & TW_TEMPER_C);
    r = r ^ (r >> 18);
    return r;
  endfunction

  function automatic logic [31:0] tkx_twist(input logic [31:0] y, input logic [31:0] x,
                                            input logic [31:0] far);
    logic [31:0] u;
    u = {1'b0, y[31], x[30:1]};
    if (x[0]) begin
      u = u ^ TW_MATRIX;
    end
    return u ^ far;
  endfunction

  function automatic logic [POS_W-1:0] tkx_next_pos(input logic [POS_W-1:0] p);
    return (p == POS_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [POS_W-1:0] tkx_far_pos(input logic [POS_W-1:0] p);
    return (p < POS_NM) ? p + POS_M : p - POS_NM;
  endfunction

endpackage

@@ rtl/tkx_ram.sv @@
module tkx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tkx_core.sv @@
module tkx_core import tkx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tkx_cmd_t          cmd,
  input  tkx_seeds_t        seeds,
  input  logic [SKIP_W-1:0] skip_count,
  input  logic              slot_free,
  output logic              busy,
  output logic              done,
  output tkx_res_t          res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_RDX  = 3'd2;
  localparam logic [2:0] S_RDM  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_PUT  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  fill_idx_r, fill_idx_nxt;
  logic [SEL_W-1:0]  sel_r, sel_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic              seeded_r, seeded_nxt;
  logic [31:0]       y_r, y_nxt;
  logic [31:0]       x_r, x_nxt;
  logic [31:0]       key_r, key_nxt;
  tkx_cmd_t          cmd_r, cmd_nxt;

  logic              ram_we;
  logic [POS_W-1:0]  ram_waddr;
  logic [31:0]       ram_wdata;
  logic [POS_W-1:0]  ram_raddr;
  logic [31:0]       ram_rdata;
  logic [POS_W-1:0]  pos_next;

  tkx_ram #(.WIDTH(32), .DEPTH(TW_N)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pos_next = tkx_next_pos(pos_r);
  assign busy     = (state_r != S_IDLE);
  assign res.word = (cmd_r.action == ACT_CIPHER) ? (cmd_r.data_word ^ key_r) : '0;
  assign res.last = cmd_r.last_word;

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    fill_idx_nxt = fill_idx_r;
    sel_nxt      = sel_r;
    left_nxt     = left_r;
    seeded_nxt   = seeded_r;
    y_nxt        = y_r;
    x_nxt        = x_r;
    key_nxt      = key_r;
    cmd_nxt      = cmd_r;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = tkx_twist(y_r, x_r, ram_rdata);
    ram_raddr    = pos_next;
    done         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = cmd;
          key_nxt = '0;
          if (cmd.action == ACT_RESEED) begin
            fill_idx_nxt = '0;
            sel_nxt      = '0;
            seeded_nxt   = 1'b1;
            y_nxt        = seeds[0];
            state_nxt    = S_FILL;
          end else if (!seeded_r) begin
            // A never-seeded state is all zero, so every draw yields zero.
            state_nxt = S_PUT;
          end else begin
            left_nxt  = (skip_count == '0) ? LEFT_W'(1) : LEFT_W'(skip_count);
            state_nxt = S_RDX;
          end
        end
      end
      S_FILL: begin
        ram_we       = 1'b1;
        ram_waddr    = fill_idx_r;
        ram_wdata    = seeds[sel_r];
        fill_idx_nxt = fill_idx_r + 1'b1;
        sel_nxt      = (sel_r == SEL_LAST) ? '0 : sel_r + 1'b1;
        if (fill_idx_r == POS_LAST) begin
          pos_nxt   = '0;
          left_nxt  = WARMUP_CNT;
          state_nxt = (WARMUP_CNT == '0) ? S_PUT : S_RDX;
        end
      end
      S_RDX: begin
        ram_raddr = pos_next;
        state_nxt = S_RDM;
      end
      S_RDM: begin
        ram_raddr = tkx_far_pos(pos_r);
        x_nxt     = ram_rdata;
        state_nxt = S_WR;
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = tkx_twist(y_r, x_r, ram_rdata);
        ram_raddr = tkx_next_pos(pos_next);
        key_nxt   = tkx_temper(y_r);
        y_nxt     = x_r;
        pos_nxt   = pos_next;
        left_nxt  = left_r - 1'b1;
        state_nxt = (left_r == LEFT_W'(1)) ? S_PUT : S_RDM;
      end
      S_PUT: begin
        if (slot_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      seeded_r <= 1'b0;
      left_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      seeded_r <= seeded_nxt;
      left_r   <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_idx_r <= fill_idx_nxt;
    sel_r      <= sel_nxt;
    y_r        <= y_nxt;
    x_r        <= x_nxt;
    key_r      <= key_nxt;
    cmd_r      <= cmd_nxt;
  end

endmodule

@@ rtl/twister_keystream_xor.sv @@
// Channel  Direction  Handshake            Word
// in       input      in_valid/in_ready    in_action, in_data_word, in_last_word
// out      output     out_valid/out_ready  out_word, out_last
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A cipher word is paced by the single read port of the state memory: each draw
// reads two words and writes one, and skip_count draws are made (one if it is 0).
// Before the first reseed a cipher word makes no draw.
// A reseed word writes all 624 state words, then makes 624 warm-up draws.
// No memory clearing pass is needed at reset, since an unseeded state is tracked
// by a flag. A stalled out channel holds one finished word while the next input
// word is accepted and worked on.
module twister_keystream_xor import tkx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [31:0]       in_data_word,
  input  logic              in_last_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_word,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [31:0]       cfg_data
);

  tkx_seeds_t        seeds_r;
  logic [SKIP_W-1:0] skip_r;
  logic              out_valid_r;
  logic [31:0]       out_word_r;
  logic              out_last_r;

  logic              busy;
  logic              done;
  logic              slot_free;
  tkx_cmd_t          cmd;
  tkx_res_t          res;

  assign cmd.action    = in_action;
  assign cmd.data_word = in_data_word;
  assign cmd.last_word = in_last_word;

  assign in_ready  = !busy;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

  tkx_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_valid && in_ready),
    .cmd        (cmd),
    .seeds      (seeds_r),
    .skip_count (skip_r),
    .slot_free  (slot_free),
    .busy       (busy),
    .done       (done),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeds_r <= '0;
      skip_r  <= SKIP_RESET;
    end else if (cfg_valid) begin
      if (cfg_index < IDX_W'(NUM_SEEDS)) begin
        seeds_r[cfg_index[SEL_W-1:0]] <= cfg_data;
      end else if (cfg_index == REG_SKIP_COUNT) begin
        skip_r <= cfg_data[SKIP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_word_r <= res.word;
      out_last_r <= res.last;
    end
  end

endmodule

@@ rtl/tkx_checker.sv @@
module tkx_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [31:0]       out_word,
  input logic              out_last
);

  // After reset the block is empty and ready for a word.
  a_reset_state: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // An accepted word keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a word");

  // A result appears only at the end of work on an input word.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind twister_keystream_xor tkx_checker u_tkx_checker (.*);

@@ dv/tb.sv @@
module tb;
  import tkx_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 150;

  localparam logic [IDX_W-1:0] REG_SEED_0 = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_SPARE  = IDX_W'(7);

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_action;
  logic [31:0]      in_data_word;
  logic             in_last_word;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [31:0]      out_word;
  logic             out_last;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [31:0]      cfg_data;

  // Shadow copy of the generator state and the register file.
  logic [31:0]       mt_words [TW_N];
  int                mt_pos;
  tkx_seeds_t        seed_cfg;
  logic [SKIP_W-1:0] skip_cfg;

  tkx_res_t pending_words [$];
  int       errors = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;

  int       hold_tag = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;

  twister_keystream_xor uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_data_word (in_data_word),
    .in_last_word (in_last_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_word),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] temper_word(input logic [31:0] raw);
    logic [31:0] t;
    t = raw ^ {11'b0, raw[31:11]};
    t = t ^ ({t[24:0], 7'b0} & TW_TEMPER_B);
    t = t ^ ({t[16:0], 15'b0} & TW_TEMPER_C);
    return t ^ {18'b0, t[31:18]};
  endfunction

  // One generator step: twists the current word in place and returns the
  // tempered value it held before the twist.
  function automatic logic [31:0] draw_key();
    int          nxt;
    int          far;
    logic [31:0] y;
    logic [31:0] x;
    logic [31:0] u;
    nxt = (mt_pos == TW_N - 1) ? 0 : mt_pos + 1;
    y = mt_words[mt_pos];
    x = mt_words[nxt];
    u = {1'b0, y[31], x[30:1]};
    if (x[0]) begin
      u = u ^ TW_MATRIX;
    end
    far = (mt_pos < TW_N - TW_M) ? mt_pos + TW_M : mt_pos - (TW_N - TW_M);
    mt_words[mt_pos] = u ^ mt_words[far];
    mt_pos = nxt;
    return temper_word(y);
  endfunction

  function automatic tkx_res_t predict_cipher(input logic act, input logic [31:0] data,
                                              input logic last);
    tkx_res_t    r;
    logic [31:0] key;
    int          draws;
    key = '0;
    if (act == ACT_RESEED) begin
      for (int i = 0; i < TW_N; i++) begin
        mt_words[i] = seed_cfg[i % NUM_SEEDS];
      end
      mt_pos = 0;
      for (int i = 0; i < WARMUP_DRAWS; i++) begin
        key = draw_key();
      end
      r.word = '0;
    end else begin
      draws = (skip_cfg == '0) ? 1 : int'(skip_cfg);
      for (int i = 0; i < draws; i++) begin
        key = draw_key();
      end
      r.word = data ^ key;
    end
    r.last = last;
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    tkx_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h last %b", $time, out_word, out_last);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (out_word !== want.word) begin
          $display("%0t: out_word expected %h actual %h", $time, want.word, out_word);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last expected %b actual %b", $time, want.last, out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen <= hold_tag;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(5, 80);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic act, input logic [31:0] data, input logic last);
    in_valid <= 1'b1;
    in_action <= act;
    in_data_word <= data;
    in_last_word <= last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pending_words.push_back(predict_cipher(act, data, last));
  endtask

  // Sends one word and inserts a random gap at the end of each burst.
  task automatic feed_word(input logic act, input logic [31:0] data, input logic last);
    send_word(act, data, last);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    if (idx < REG_SKIP_COUNT) begin
      seed_cfg[idx] = val;
    end else if (idx == REG_SKIP_COUNT) begin
      skip_cfg = val[SKIP_W-1:0];
    end
    if (!more) begin
      cfg_valid <= 1'b0;
    end
  endtask

  task automatic configure(input tkx_seeds_t seeds, input logic [31:0] skip_val,
                           input bit touch_spare);
    for (int i = 0; i < NUM_SEEDS; i++) begin
      write_reg(REG_SEED_0 + IDX_W'(i), seeds[i], 1'b1);
    end
    if (touch_spare) begin
      write_reg(REG_SPARE, $urandom, 1'b1);
    end
    write_reg(REG_SKIP_COUNT, skip_val, 1'b0);
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_unseeded();
    feed_word(ACT_CIPHER, 32'h0, 1'b0);
    feed_word(ACT_CIPHER, 32'hffffffff, 1'b1);
    feed_word(ACT_CIPHER, $urandom, 1'b0);
  endtask

  task automatic test_register_writes();
    tkx_seeds_t seeds;
    drain_words();
    seeds = {32'hffffffff, 32'h0, 32'h80000001, 32'h7ffffffe, 32'h12345678, 32'hc3a5965a};
    configure(seeds, 32'hffffffe0 | 32'd16, 1'b1);
    feed_word(ACT_RESEED, $urandom, 1'b1);
    feed_word(ACT_CIPHER, 32'h0, 1'b0);
    feed_word(ACT_CIPHER, 32'hffffffff, 1'b0);
    feed_word(ACT_CIPHER, 32'h55555555, 1'b1);
  endtask

  task automatic test_skip_extremes();
    logic [31:0] skips [4];
    skips = '{32'd0, 32'd1, 32'd31, 32'd16};
    for (int i = 0; i < 4; i++) begin
      drain_words();
      write_reg(REG_SKIP_COUNT, skips[i], 1'b0);
      feed_word(ACT_CIPHER, $urandom, 1'b0);
      feed_word(ACT_CIPHER, $urandom, 1'b1);
    end
  endtask

  task automatic test_reseed_cases();
    tkx_seeds_t seeds;
    drain_words();
    configure('0, 32'd3, 1'b0);
    feed_word(ACT_RESEED, $urandom, 1'b0);
    feed_word(ACT_CIPHER, $urandom, 1'b1);
    drain_words();
    for (int i = 0; i < NUM_SEEDS; i++) begin
      seeds[i] = $urandom;
    end
    configure(seeds, 32'd16, 1'b0);
    send_word(ACT_RESEED, $urandom, 1'b0);
    send_word(ACT_RESEED, $urandom, 1'b1);
    feed_word(ACT_CIPHER, $urandom, 1'b1);
  endtask

  task automatic test_backpressure();
    drain_words();
    hold_tag++;
    while (hold_seen != hold_tag) begin
      @(posedge clk);
    end
    for (int i = 0; i < 10; i++) begin
      send_word(ACT_CIPHER, $urandom, (i == 9));
    end
    drain_words();
  endtask

  task automatic test_random_traffic();
    tkx_seeds_t seeds;
    logic       act;
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_words();
      for (int i = 0; i < NUM_SEEDS; i++) begin
        seeds[i] = pick_seed();
      end
      configure(seeds, $urandom, ($urandom_range(0, 1) == 1));
      feed_word(ACT_RESEED, $urandom, 1'($urandom_range(0, 1)));
      for (int n = 1; n < PHASE_WORDS; n++) begin
        act = ($urandom_range(0, 49) == 0) ? ACT_RESEED : ACT_CIPHER;
        feed_word(act, $urandom, ($urandom_range(0, 7) == 0));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < TW_N; i++) begin
      mt_words[i] = '0;
    end
    mt_pos = 0;
    seed_cfg = '0;
    skip_cfg = SKIP_RESET;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_CIPHER;
    in_data_word = '0;
    in_last_word = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unseeded();
    test_register_writes();
    test_skip_extremes();
    test_reseed_cases();
    test_backpressure();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
